### hdl/nurt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nurt_pkg
// Shared constants of the neighbor utility rank table.
// ----------------------------------------------------------------------------
package nurt_pkg;
  localparam int DEPTH_DEF = 32;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] W_LOW_MAX = 16'd39321;
  localparam logic [15:0] W_MID_MAX = 16'd52428;
  localparam logic [16:0] W_TINY = 17'd66;
  localparam logic [0:0] REQ_BEACON = 1'b0;
  localparam logic [0:0] REQ_LIST = 1'b1;
  localparam logic [0:0] KIND_STATUS = 1'b0;
  localparam logic [0:0] KIND_LIST = 1'b1;
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;
  localparam logic [0:0] REG_NNORM = 1'b0;
  localparam logic [0:0] REG_RNORM = 1'b1;
endpackage

### hdl/neighbor_utility_rank_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_utility_rank_table_unit
// Neighbor table keyed by address, utility computed per beacon, sorted list.
// ----------------------------------------------------------------------------
// Beacon: two 32-step restoring divides on one shared unit, a weight multiply,
// then a table scan that reads and compares one entry at a time up to the
// match or the end of the list, then the status beat. List: a selection pass
// over all entries for each beat, plus output stalls. One item at a time.
// Reset clears the entry count and the control state and restores the default
// normalisers; the table memory needs no clearing pass.
module neighbor_utility_rank_table_unit
  import nurt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // sender_addr, busy_ratio, distance, neighbor_count
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // entry_addr, entry_utility
  output logic [2:0]  out_tuser,  // item_kind, status[1:0]
  output logic        out_tlast   // last
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVN, S_DIVD, S_MUL, S_SCAN, S_SCANW, S_LSTART, S_LREAD, S_LWAIT,
    S_LEMIT, S_OUT
  } state_t;

  state_t state_r;
  logic [7:0]  nnorm_r;
  logic [15:0] rnorm_r;
  logic [CW-1:0] count_r;
  logic [15:0] addr_r, cbr_r, dist_r;
  logic [16:0] nterm_r;
  logic [31:0] quo_r;
  logic [16:0] rem_r;
  logic [4:0]  step_r;
  logic [15:0] util_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] emitted_r;
  logic [31:0] bound_r, best_r;
  logic        has_bound_r, found_r;
  logic [15:0] mem_addr [TABLE_DEPTH];
  logic [15:0] mem_util [TABLE_DEPTH];
  logic [15:0] rd_addr_r, rd_util_r;
  logic        we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic        ov_r;
  logic [31:0] ov_data_r;
  logic [2:0]  ov_user_r;
  logic        ov_last_r;

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = ov_data_r;
  assign out_tuser = ov_user_r;
  assign out_tlast = ov_last_r;

  // shared divider step
  logic [15:0] div_den;
  logic [16:0] trial;
  logic [16:0] rem_nxt;
  logic [31:0] quo_nxt;
  assign div_den = (state_r == S_DIVN) ? {8'd0, nnorm_r} : rnorm_r;
  always_comb begin
    trial = {rem_r[15:0], quo_r[31]} - {1'b0, div_den};
    if (!trial[16]) begin
      rem_nxt = trial;
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[15:0], quo_r[31]};
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  logic [16:0] weight;
  logic [17:0] wsum;
  logic [34:0] prod;
  logic [16:0] dterm;
  assign dterm = (rnorm_r == 16'd0 || quo_r > {15'd0, ONE_Q16}) ? ONE_Q16 : quo_r[16:0];
  always_comb begin
    if (cbr_r <= W_LOW_MAX) weight = ONE_Q16;
    else if (cbr_r <= W_MID_MAX) weight = ONE_Q16 - {1'b0, cbr_r};
    else weight = W_TINY;
    wsum = {1'b0, nterm_r} + {1'b0, dterm};
    prod = weight * wsum;
  end

  logic [31:0] key;
  assign key = {rd_util_r, rd_addr_r};
  logic emit_ok;
  assign emit_ok = !ov_r || out_tready;
  logic ov_load;
  assign ov_load = ((state_r == S_OUT) || (state_r == S_LEMIT)) && emit_ok;

  assign raddr = idx_r[AW-1:0];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_addr[waddr] <= addr_r;
      mem_util[waddr] <= util_r;
    end
    rd_addr_r <= mem_addr[raddr];
    rd_util_r <= mem_util[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    if (state_r == S_SCANW) begin
      if (idx_r < count_r && rd_addr_r == addr_r) we = 1'b1;
      else if (idx_r >= count_r && count_r < CW'(TABLE_DEPTH)) we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nnorm_r <= 8'd10;
      rnorm_r <= 16'd300;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NNORM) nnorm_r <= cfg_wdata[7:0];
        else rnorm_r <= cfg_wdata;
      end
      if (ov_load) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          addr_r <= in_tdata[15:0];
          cbr_r <= in_tdata[31:16];
          dist_r <= in_tdata[47:32];
          if (in_tuser == REQ_LIST) begin
            emitted_r <= '0;
            has_bound_r <= 1'b0;
            state_r <= S_LSTART;
          end else begin
            quo_r <= {8'd0, in_tdata[55:48], 16'd0};
            rem_r <= '0;
            step_r <= '0;
            state_r <= S_DIVN;
          end
        end
        S_DIVN, S_DIVD: begin
          if (step_r == 5'd31) begin
            step_r <= '0;
            if (state_r == S_DIVN) begin
              rem_r <= '0;
              quo_r <= {dist_r, 16'd0};
              if (nnorm_r == 8'd0) nterm_r <= ONE_Q16;
              else nterm_r <= (quo_nxt > {15'd0, ONE_Q16}) ? ONE_Q16 : quo_nxt[16:0];
              state_r <= S_DIVD;
            end else begin
              rem_r <= rem_nxt;
              quo_r <= quo_nxt;
              state_r <= S_MUL;
            end
          end else begin
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            step_r <= step_r + 5'd1;
          end
        end
        S_MUL: begin
          util_r <= (prod[34:17] > 18'd65535) ? 16'hFFFF : prod[32:17];
          idx_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: state_r <= S_SCANW;
        S_SCANW: begin
          if (idx_r < count_r && rd_addr_r == addr_r) begin
            ov_data_r <= {util_r, addr_r};
            ov_user_r <= {ST_UPDATED, KIND_STATUS};
            ov_last_r <= 1'b1;
            state_r <= S_OUT;
          end else if (idx_r >= count_r) begin
            ov_data_r <= {util_r, addr_r};
            ov_last_r <= 1'b1;
            if (count_r < CW'(TABLE_DEPTH)) begin
              ov_user_r <= {ST_INSERTED, KIND_STATUS};
              count_r <= count_r + CW'(1);
            end else begin
              ov_user_r <= {ST_DROPPED, KIND_STATUS};
            end
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_SCAN;
          end
        end
        S_OUT: if (emit_ok) begin
          state_r <= S_IDLE;
        end
        S_LSTART: begin
          if (count_r == '0) begin
            ov_data_r <= '0;
            ov_user_r <= {ST_EMPTY, KIND_LIST};
            ov_last_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            idx_r <= '0;
            found_r <= 1'b0;
            best_r <= '0;
            state_r <= S_LREAD;
          end
        end
        S_LREAD: state_r <= S_LWAIT;
        S_LWAIT: begin
          if ((!has_bound_r || key < bound_r) && (!found_r || key > best_r)) begin
            best_r <= key;
            found_r <= 1'b1;
          end
          if (idx_r + CW'(1) >= count_r) state_r <= S_LEMIT;
          else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_LREAD;
          end
        end
        S_LEMIT: if (emit_ok) begin
          ov_data_r <= {best_r[31:16], best_r[15:0]};
          ov_user_r <= {ST_INSERTED, KIND_LIST};
          ov_last_r <= (emitted_r + CW'(1) == count_r);
          emitted_r <= emitted_r + CW'(1);
          bound_r <= best_r;
          has_bound_r <= 1'b1;
          idx_r <= '0;
          found_r <= 1'b0;
          state_r <= (emitted_r + CW'(1) == count_r) ? S_IDLE : S_LREAD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(TABLE_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(ov_data_r)) else $error("beat lost");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready while busy");
  a_best_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEMIT |-> found_r) else $error("list beat without entry");
endmodule
